// ----- design/srsw_pkg.sv -----
// ----------------------------------------------------------------------------
// srsw_pkg
// Types and constants shared by the selective-repeat sender window core.
// ----------------------------------------------------------------------------
package srsw_pkg;

   // Window geometry and sequence space
   localparam int WINDOW      = 10;
   localparam int SEQ_SPACE   = 25601;
   localparam int MAX_PAYLOAD = 512;

   localparam int SLOT_W  = $clog2(WINDOW);
   localparam int CNT_W   = $clog2(WINDOW + 1);
   localparam int SEQ_W   = 15;
   localparam int LEN_W   = 10;
   localparam int TIMER_W = 20;

   localparam logic [SEQ_W:0]   SEQ_SPACE_WIDE = (SEQ_W + 1)'(SEQ_SPACE);
   localparam logic [LEN_W-1:0] MAX_LEN        = LEN_W'(MAX_PAYLOAD);
   localparam logic [TIMER_W-1:0] RETX_RESET   = TIMER_W'(500);

   // Operation codes of an input item
   localparam logic [1:0] OP_SEND = 2'd0;
   localparam logic [1:0] OP_ACK  = 2'd1;
   localparam logic [1:0] OP_TICK = 2'd2;

   // Configuration register indexes
   localparam logic CSR_INIT_SEQ = 1'b0;
   localparam logic CSR_RETX     = 1'b1;

   // Event codes of a result item
   typedef enum logic [2:0] {
      EV_SENT    = 3'd0,
      EV_REFUSED = 3'd1,
      EV_MATCHED = 3'd2,
      EV_IGNORED = 3'd3,
      EV_RETX    = 3'd4
   } event_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEND,
      ST_ACK_SCAN,
      ST_BASE_ADV,
      ST_TICK_SCAN,
      ST_EMIT_LAST
   } state_type;

   typedef struct packed {
      logic [1:0]       operation;
      logic [LEN_W-1:0] segment_length;
      logic [SEQ_W-1:0] ack_number;
   } req_type;

   typedef struct packed {
      logic [2:0]       event_kind;
      logic [3:0]       slot_index;
      logic [SEQ_W-1:0] sequence_number;
      logic [LEN_W-1:0] length_out;
      logic [3:0]       window_base;
      logic [3:0]       in_flight;
      logic             last_result;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic      capture;
      logic      send_commit;
      logic      scan_adv;
      logic      mark_acked;
      logic      base_adv;
      logic      timer_reload;
      logic      timer_dec;
      logic      pend_load;
      event_type pend_kind;
      logic      emit;
      logic      emit_last;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic window_full;
      logic scan_done;
      logic slot_acked;
      logic ack_match;
      logic timer_expired;
      logic base_acked;
      logic pend_valid;
      logic out_free;
   } status_type;

endpackage

// ----- design/srsw_ctrl.sv -----
// ----------------------------------------------------------------------------
// srsw_ctrl
// Sequencer for send, ack scan, base advance and tick scan of the window.
// ----------------------------------------------------------------------------
module srsw_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [1:0]           req_operation,
   output logic                 req_ready,
   input  srsw_pkg::status_type stat,
   output srsw_pkg::cmd_type    cmd
);

   srsw_pkg::state_type state_ff, state_in;

   // Hold state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= srsw_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Decode next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         srsw_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               case (req_operation)
                  srsw_pkg::OP_SEND: state_in = srsw_pkg::ST_SEND;
                  srsw_pkg::OP_ACK:  state_in = srsw_pkg::ST_ACK_SCAN;
                  srsw_pkg::OP_TICK: state_in = srsw_pkg::ST_TICK_SCAN;
                  default:           state_in = srsw_pkg::ST_IDLE;
               endcase
            end
         end
         srsw_pkg::ST_SEND: begin
            cmd.pend_load = 1'b1;
            if (stat.window_full) begin
               cmd.pend_kind = srsw_pkg::EV_REFUSED;
            end else begin
               cmd.pend_kind   = srsw_pkg::EV_SENT;
               cmd.send_commit = 1'b1;
            end
            state_in = srsw_pkg::ST_EMIT_LAST;
         end
         srsw_pkg::ST_ACK_SCAN: begin
            if (stat.scan_done) begin
               cmd.pend_load = 1'b1;
               cmd.pend_kind = srsw_pkg::EV_IGNORED;
               state_in      = srsw_pkg::ST_EMIT_LAST;
            end else if (!stat.slot_acked && stat.ack_match) begin
               cmd.mark_acked = 1'b1;
               cmd.pend_load  = 1'b1;
               cmd.pend_kind  = srsw_pkg::EV_MATCHED;
               state_in       = srsw_pkg::ST_BASE_ADV;
            end else begin
               cmd.scan_adv = 1'b1;
            end
         end
         srsw_pkg::ST_BASE_ADV: begin
            // Drop acknowledged slots off the front, one per cycle
            if (stat.base_acked) begin
               cmd.base_adv = 1'b1;
            end else begin
               state_in = srsw_pkg::ST_EMIT_LAST;
            end
         end
         srsw_pkg::ST_TICK_SCAN: begin
            if (stat.scan_done) begin
               state_in = stat.pend_valid ? srsw_pkg::ST_EMIT_LAST : srsw_pkg::ST_IDLE;
            end else if (stat.slot_acked) begin
               cmd.scan_adv = 1'b1;
            end else if (stat.timer_expired) begin
               // Stall while an earlier expiry cannot move to the output
               if (!stat.pend_valid || stat.out_free) begin
                  cmd.timer_reload = 1'b1;
                  cmd.emit         = stat.pend_valid;
                  cmd.pend_load    = 1'b1;
                  cmd.pend_kind    = srsw_pkg::EV_RETX;
                  cmd.scan_adv     = 1'b1;
               end
            end else begin
               cmd.timer_dec = 1'b1;
               cmd.scan_adv  = 1'b1;
            end
         end
         srsw_pkg::ST_EMIT_LAST: begin
            if (stat.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_last = 1'b1;
               state_in      = srsw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = srsw_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ----- design/srsw_dpath.sv -----
// ----------------------------------------------------------------------------
// srsw_dpath
// Slot registers, window pointers, sequence arithmetic and result registers.
// ----------------------------------------------------------------------------
module srsw_dpath (
   input  logic                       clock,
   input  logic                       reset,
   input  srsw_pkg::req_type          req_data,
   input  logic                       csr_write_enable,
   input  logic                       csr_index,
   input  logic [srsw_pkg::TIMER_W-1:0] csr_wdata,
   input  srsw_pkg::cmd_type          cmd,
   output srsw_pkg::status_type       stat,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   output srsw_pkg::rsp_type          rsp_data
);

   localparam int SLOT_W  = srsw_pkg::SLOT_W;
   localparam int CNT_W   = srsw_pkg::CNT_W;
   localparam int SEQ_W   = srsw_pkg::SEQ_W;
   localparam int LEN_W   = srsw_pkg::LEN_W;
   localparam int TIMER_W = srsw_pkg::TIMER_W;
   localparam int WINDOW  = srsw_pkg::WINDOW;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);
   localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(WINDOW);

   // Slot storage
   logic [SEQ_W-1:0]   slot_seq_ff   [WINDOW];
   logic [LEN_W-1:0]   slot_len_ff   [WINDOW];
   logic [TIMER_W-1:0] slot_timer_ff [WINDOW];
   logic [WINDOW-1:0]  slot_acked_ff, slot_acked_in;

   // Window pointers and counters
   logic [SLOT_W-1:0]  base_ff, base_in, tail_ff, tail_in, sp_ff, sp_in;
   logic [CNT_W-1:0]   count_ff, count_in, sc_ff, sc_in;
   logic [SEQ_W-1:0]   next_seq_ff, next_seq_in;
   logic [TIMER_W-1:0] retx_ff, retx_in;

   // Captured item
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [SEQ_W-1:0]   ack_ff, ack_in;

   // Pending result and output register
   logic [2:0]         pend_kind_ff, pend_kind_in;
   logic [SLOT_W-1:0]  pend_slot_ff, pend_slot_in;
   logic [SEQ_W-1:0]   pend_seq_ff, pend_seq_in;
   logic [LEN_W-1:0]   pend_len_ff, pend_len_in;
   logic               pend_valid_ff, pend_valid_in;
   logic               rsp_valid_ff, rsp_valid_in;
   srsw_pkg::rsp_type  rsp_ff, rsp_in;

   logic [SLOT_W-1:0]  sp_next, base_next, tail_next;
   logic [SEQ_W:0]     ack_sum, ack_wrap, seq_sum, seq_wrap, init_wide, init_wrap;
   logic               init_write, retx_write, out_free;

   // Ring increments
   assign sp_next   = (sp_ff == LAST_SLOT)   ? '0 : sp_ff + 1'b1;
   assign base_next = (base_ff == LAST_SLOT) ? '0 : base_ff + 1'b1;
   assign tail_next = (tail_ff == LAST_SLOT) ? '0 : tail_ff + 1'b1;

   // End of the scanned segment, modulo the sequence space
   assign ack_sum  = {1'b0, slot_seq_ff[sp_ff]} + (SEQ_W + 1)'(slot_len_ff[sp_ff]);
   assign ack_wrap = (ack_sum >= srsw_pkg::SEQ_SPACE_WIDE) ?
                     ack_sum - srsw_pkg::SEQ_SPACE_WIDE : ack_sum;

   // Advance of the next sequence number
   assign seq_sum  = {1'b0, next_seq_ff} + (SEQ_W + 1)'(len_ff);
   assign seq_wrap = (seq_sum >= srsw_pkg::SEQ_SPACE_WIDE) ?
                     seq_sum - srsw_pkg::SEQ_SPACE_WIDE : seq_sum;

   // Reduce a written initial sequence into the space
   assign init_wide = {1'b0, csr_wdata[SEQ_W-1:0]};
   assign init_wrap = (init_wide >= srsw_pkg::SEQ_SPACE_WIDE) ?
                      init_wide - srsw_pkg::SEQ_SPACE_WIDE : init_wide;

   assign init_write = csr_write_enable && (csr_index == srsw_pkg::CSR_INIT_SEQ);
   assign retx_write = csr_write_enable && (csr_index == srsw_pkg::CSR_RETX);
   assign out_free   = !rsp_valid_ff || rsp_ready;

   // Report status
   always_comb begin
      stat.window_full   = (count_ff == FULL_CNT);
      stat.scan_done     = (sc_ff == count_ff);
      stat.slot_acked    = slot_acked_ff[sp_ff];
      stat.ack_match     = (ack_wrap[SEQ_W-1:0] == ack_ff);
      stat.timer_expired = (slot_timer_ff[sp_ff] <= TIMER_W'(1));
      stat.base_acked    = (count_ff != '0) && slot_acked_ff[base_ff];
      stat.pend_valid    = pend_valid_ff;
      stat.out_free      = out_free;
   end

   // Next values of pointers, flags and result registers
   always_comb begin
      base_in       = base_ff;
      tail_in       = tail_ff;
      sp_in         = sp_ff;
      count_in      = count_ff;
      sc_in         = sc_ff;
      next_seq_in   = next_seq_ff;
      retx_in       = retx_ff;
      slot_acked_in = slot_acked_ff;
      len_in        = len_ff;
      ack_in        = ack_ff;
      pend_kind_in  = pend_kind_ff;
      pend_slot_in  = pend_slot_ff;
      pend_seq_in   = pend_seq_ff;
      pend_len_in   = pend_len_ff;
      pend_valid_in = pend_valid_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;

      // Empty the window on a new initial sequence
      if (init_write) begin
         base_in       = '0;
         tail_in       = '0;
         count_in      = '0;
         slot_acked_in = '0;
         next_seq_in   = init_wrap[SEQ_W-1:0];
      end
      if (retx_write) begin
         retx_in = csr_wdata;
      end

      // Capture the item, saturating the length
      if (cmd.capture) begin
         len_in = (req_data.segment_length > srsw_pkg::MAX_LEN) ?
                  srsw_pkg::MAX_LEN : req_data.segment_length;
         ack_in = req_data.ack_number;
         sp_in  = base_ff;
         sc_in  = '0;
      end
      if (cmd.scan_adv) begin
         sp_in = sp_next;
         sc_in = sc_ff + 1'b1;
      end

      // Append a segment at the tail
      if (cmd.send_commit) begin
         slot_acked_in[tail_ff] = 1'b0;
         next_seq_in            = seq_wrap[SEQ_W-1:0];
         tail_in                = tail_next;
         count_in               = count_ff + 1'b1;
      end
      if (cmd.mark_acked) begin
         slot_acked_in[sp_ff] = 1'b1;
      end
      if (cmd.base_adv) begin
         base_in  = base_next;
         count_in = count_ff - 1'b1;
      end

      // Move the pending result out before loading a new one
      if (cmd.emit) begin
         rsp_in.event_kind      = pend_kind_ff;
         rsp_in.slot_index      = 4'(pend_slot_ff);
         rsp_in.sequence_number = pend_seq_ff;
         rsp_in.length_out      = pend_len_ff;
         rsp_in.window_base     = 4'(base_ff);
         rsp_in.in_flight       = 4'(count_ff);
         rsp_in.last_result     = cmd.emit_last;
         rsp_valid_in           = 1'b1;
         pend_valid_in          = 1'b0;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.pend_load) begin
         pend_valid_in = 1'b1;
         pend_kind_in  = cmd.pend_kind;
         case (cmd.pend_kind)
            srsw_pkg::EV_SENT, srsw_pkg::EV_REFUSED: begin
               pend_slot_in = tail_ff;
               pend_seq_in  = next_seq_ff;
               pend_len_in  = len_ff;
            end
            srsw_pkg::EV_MATCHED, srsw_pkg::EV_RETX: begin
               pend_slot_in = sp_ff;
               pend_seq_in  = slot_seq_ff[sp_ff];
               pend_len_in  = slot_len_ff[sp_ff];
            end
            default: begin
               pend_slot_in = '0;
               pend_seq_in  = '0;
               pend_len_in  = '0;
            end
         endcase
      end
   end

   // Hold control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         next_seq_ff   <= '0;
         retx_ff       <= srsw_pkg::RETX_RESET;
         slot_acked_ff <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         base_ff       <= base_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         next_seq_ff   <= next_seq_in;
         retx_ff       <= retx_in;
         slot_acked_ff <= slot_acked_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Hold payload registers
   always_ff @(posedge clock) begin
      sp_ff        <= sp_in;
      sc_ff        <= sc_in;
      len_ff       <= len_in;
      ack_ff       <= ack_in;
      pend_kind_ff <= pend_kind_in;
      pend_slot_ff <= pend_slot_in;
      pend_seq_ff  <= pend_seq_in;
      pend_len_ff  <= pend_len_in;
      rsp_ff       <= rsp_in;
   end

   // Write slot entries
   always_ff @(posedge clock) begin
      if (cmd.send_commit) begin
         slot_seq_ff[tail_ff]   <= next_seq_ff;
         slot_len_ff[tail_ff]   <= len_ff;
         slot_timer_ff[tail_ff] <= retx_ff;
      end
      if (cmd.timer_reload) begin
         slot_timer_ff[sp_ff] <= retx_ff;
      end else if (cmd.timer_dec) begin
         slot_timer_ff[sp_ff] <= slot_timer_ff[sp_ff] - 1'b1;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- design/selective_repeat_sender_window_core.sv -----
// Sender side of a selective-repeat window over ten slots. A send item goes
// from acceptance through the send state and the emit state to its result in
// the output register. An ack item scans slots from the base, up to the number
// in flight, until the matching slot, then drops acknowledged slots off the
// front before its result is emitted.
// A tick item scans the occupied slots; a tick with no expiry gives no result.
// The scan reads one slot register per cycle while it is not paused.
// Retransmissions of one tick leave in slot order, the last one flagged; the
// scan pauses while the output register is still taken. Configuration is to
// be written by the user only while the core is idle; the core itself does
// not enforce this. A write of the initial sequence empties the window.
// ----------------------------------------------------------------------------
// selective_repeat_sender_window_core
// Top level: joins the window sequencer to the slot datapath.
// ----------------------------------------------------------------------------
module selective_repeat_sender_window_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  srsw_pkg::req_type            req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output srsw_pkg::rsp_type            rsp_data,
   input  logic                         csr_write_enable,
   input  logic                         csr_index,
   input  logic [srsw_pkg::TIMER_W-1:0] csr_wdata
);

   srsw_pkg::cmd_type    cmd;
   srsw_pkg::status_type stat;

   srsw_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_data.operation),
      .req_ready     (req_ready),
      .stat          (stat),
      .cmd           (cmd)
   );

   srsw_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_data         (req_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_data         (rsp_data)
   );

endmodule

// ----- design/srsw_checker.sv -----
// ----------------------------------------------------------------------------
// srsw_checker
// Port-level checks of the sender window core, attached by bind.
// ----------------------------------------------------------------------------
module srsw_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input srsw_pkg::req_type            req_data,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input srsw_pkg::rsp_type            rsp_data,
   input logic                         csr_write_enable,
   input logic                         csr_index,
   input logic [srsw_pkg::TIMER_W-1:0] csr_wdata
);

   // Hold a stalled result transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // Keep occupancy and base inside the window
   a_window_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.in_flight <= 4'(srsw_pkg::WINDOW)) &&
                    (rsp_data.window_base < 4'(srsw_pkg::WINDOW)))
      else $error("window base or occupancy out of range");

   // Flag every non-retransmit result as the last of its item
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.event_kind != srsw_pkg::EV_RETX) |-> rsp_data.last_result)
      else $error("single result not flagged last");

   // Zero the slot fields of an ignored ack
   a_ignored_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.event_kind == srsw_pkg::EV_IGNORED) |->
         (rsp_data.slot_index == '0) && (rsp_data.sequence_number == '0) &&
         (rsp_data.length_out == '0))
      else $error("ignored ack carries slot data");

   // Report a refusal only with a full window
   a_refused_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.event_kind == srsw_pkg::EV_REFUSED) |->
         (rsp_data.in_flight == 4'(srsw_pkg::WINDOW)))
      else $error("send refused with room in window");

endmodule

bind selective_repeat_sender_window_core srsw_checker u_srsw_checker (.*);
